// ===== rtl/unordered_key_set_assert.svh =====
// Assertion macros used by the key set checker.
`ifndef UNORDERED_KEY_SET_ASSERT_SVH
`define UNORDERED_KEY_SET_ASSERT_SVH

// Checked outside reset.
`define UKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define UKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/uks_pkg.sv =====
// Types, constants and control structs for the unordered key set.
package uks_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_W  = 32;
  localparam int POS_W  = 4;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_CONTAINS,
    OP_REMOVE,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NULL,
    ST_DUP,
    ST_NOTFOUND,
    ST_FULL,
    ST_RANGE
  } status_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_SCAN,
    RD_LAST
  } rd_sel_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_HIT,
    SLOT_COUNT,
    SLOT_POS
  } slot_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_RESOLVE,
    S_RDWAIT,
    S_MOVE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic      latch_in;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      scan_step;
    logic      scan_check;
    logic      write_add;
    logic      write_move;
    logic      set_res;
    status_t   res_status;
    slot_sel_t res_slot;
    logic      res_rkey;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic key_null;
    logic pos_ok;
    logic empty;
    logic full;
    logic hit;
    logic last;
    logic found;
  } dp_stat_t;

endpackage

// ===== rtl/uks_if.sv =====
// Request and response channel interfaces of the key set.
interface uks_req_if;
  import uks_pkg::*;

  logic              valid;
  logic              ready;
  op_t               op;
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  position;

  modport source (output valid, op, key, position, input ready);
  modport sink (input valid, op, key, position, output ready);
endinterface

interface uks_rsp_if;
  import uks_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  read_key;
  logic [CNT_W-1:0]  count;

  modport source (output valid, status, slot, read_key, count, input ready);
  modport sink (input valid, status, slot, read_key, count, output ready);
endinterface

// ===== rtl/uks_dp.sv =====
// Key set datapath: key memory, scan counters, entry count and result registers.
module uks_dp #(
  parameter int CAPACITY = uks_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = uks_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  uks_pkg::dp_cmd_t              cmd,
  output uks_pkg::dp_stat_t             stat,
  input  uks_pkg::op_t                  req_op,
  input  logic [uks_pkg::KEY_W-1:0]     req_key,
  input  logic [uks_pkg::POS_W-1:0]     req_position,
  output uks_pkg::status_t              rsp_status,
  output logic [uks_pkg::SLOT_W-1:0]    rsp_slot,
  output logic [uks_pkg::KEY_W-1:0]     rsp_read_key,
  output logic [uks_pkg::CNT_W-1:0]     rsp_count
);
  import uks_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  op_t                op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [POS_W-1:0]   pos_q;
  logic [CW-1:0]      count;
  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rdata;
  logic [AW-1:0]      scan_ptr;
  logic [AW-1:0]      tag;
  logic [AW-1:0]      hit_idx;
  logic               found;
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [KEY_W-1:0]   res_rkey;

  logic [KEY_W+KEY_BITS-1:0] key_ext;
  logic [KEY_BITS-1:0]       key_in;
  logic [AW+POS_W-1:0]       pos_ext;
  logic [AW-1:0]             pos_addr;
  logic [CW+POS_W-1:0]       pos_wide;
  logic [CW+POS_W-1:0]       count_wide;
  logic [CW-1:0]             count_m1;
  logic [AW-1:0]             last_addr;
  logic [AW-1:0]             rd_addr;
  logic [AW+SLOT_W-1:0]      hit_ext;
  logic [CW+SLOT_W-1:0]      cnt_slot_ext;
  logic [CW+CNT_W-1:0]       cnt_out_ext;
  logic [KEY_BITS+KEY_W-1:0] rkey_ext;
  logic [SLOT_W-1:0]         slot_mux;

  assign key_ext      = {{KEY_BITS{1'b0}}, req_key};
  assign key_in       = key_ext[KEY_BITS-1:0];
  assign pos_ext      = {{AW{1'b0}}, pos_q};
  assign pos_addr     = pos_ext[AW-1:0];
  assign pos_wide     = {{CW{1'b0}}, pos_q};
  assign count_wide   = {{POS_W{1'b0}}, count};
  assign count_m1     = count - CW'(1);
  assign last_addr    = count_m1[AW-1:0];
  assign hit_ext      = {{SLOT_W{1'b0}}, hit_idx};
  assign cnt_slot_ext = {{SLOT_W{1'b0}}, count};
  assign cnt_out_ext  = {{CNT_W{1'b0}}, count};
  assign rkey_ext     = {{KEY_W{1'b0}}, rdata};

  always_comb begin
    case (cmd.rd_sel)
      RD_POS:  rd_addr = pos_addr;
      RD_SCAN: rd_addr = scan_ptr;
      default: rd_addr = last_addr;
    endcase
  end

  always_comb begin
    case (cmd.res_slot)
      SLOT_HIT:   slot_mux = hit_ext[SLOT_W-1:0];
      SLOT_COUNT: slot_mux = cnt_slot_ext[SLOT_W-1:0];
      SLOT_POS:   slot_mux = pos_q;
      default:    slot_mux = '0;
    endcase
  end

  assign stat.op       = op_q;
  assign stat.key_null = (key_q == '0);
  assign stat.pos_ok   = (pos_wide < count_wide);
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.hit      = (rdata == key_q);
  assign stat.last     = (tag == last_addr);
  assign stat.found    = found;

  // key memory, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.write_add) begin
      mem[count[AW-1:0]] <= key_q;
    end else if (cmd.write_move) begin
      mem[hit_idx] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q  <= req_op;
      key_q <= key_in;
      pos_q <= req_position;
    end
    if (cmd.latch_in) begin
      scan_ptr <= '0;
    end else if (cmd.scan_step) begin
      tag      <= scan_ptr;
      scan_ptr <= scan_ptr + AW'(1);
    end
    if (cmd.scan_check) begin
      hit_idx <= tag;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_slot   <= slot_mux;
      res_rkey   <= cmd.res_rkey ? rkey_ext[KEY_W-1:0] : '0;
    end
    if (cmd.load_out) begin
      rsp_status   <= res_status;
      rsp_slot     <= res_slot;
      rsp_read_key <= res_rkey;
      rsp_count    <= cnt_out_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.write_add) begin
        count <= count + CW'(1);
      end else if (cmd.write_move) begin
        count <= count_m1;
      end
      if (cmd.latch_in) begin
        found <= 1'b0;
      end else if (cmd.scan_check) begin
        found <= stat.hit;
      end
    end
  end

endmodule

// ===== rtl/uks_ctrl.sv =====
// Key set controller: request sequencing, scan control and response handshake.
module uks_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  uks_pkg::dp_stat_t stat,
  output uks_pkg::dp_cmd_t  cmd,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready
);
  import uks_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op == OP_READ) begin
          if (stat.pos_ok) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_POS;
            state_next = S_RDWAIT;
          end else begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_RANGE;
            cmd.res_slot   = SLOT_ZERO;
            state_next     = S_FINISH;
          end
        end else if (stat.key_null) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NULL;
          cmd.res_slot   = SLOT_ZERO;
          state_next     = S_FINISH;
        end else if (stat.empty) begin
          state_next = S_RESOLVE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_SCAN;
          cmd.scan_step = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.last) begin
          cmd.scan_check = 1'b1;
          state_next     = S_RESOLVE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_SCAN;
          cmd.scan_step = 1'b1;
        end
      end
      S_RESOLVE: begin
        state_next = S_FINISH;
        case (stat.op)
          OP_ADD: begin
            cmd.set_res = 1'b1;
            if (stat.found) begin
              cmd.res_status = ST_DUP;
              cmd.res_slot   = SLOT_HIT;
            end else if (stat.full) begin
              cmd.res_status = ST_FULL;
              cmd.res_slot   = SLOT_ZERO;
            end else begin
              cmd.write_add  = 1'b1;
              cmd.res_status = ST_OK;
              cmd.res_slot   = SLOT_COUNT;
            end
          end
          OP_REMOVE: begin
            if (stat.found) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_next = S_MOVE;
            end else begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              cmd.res_slot   = SLOT_ZERO;
            end
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = stat.found ? ST_OK : ST_NOTFOUND;
            cmd.res_slot   = stat.found ? SLOT_HIT : SLOT_ZERO;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_slot   = SLOT_POS;
        cmd.res_rkey   = 1'b1;
        state_next     = S_FINISH;
      end
      S_MOVE: begin
        // last entry fills the freed slot
        cmd.write_move = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_slot   = SLOT_HIT;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp_valid_next = (rsp_valid && !rsp_ready) || cmd.load_out;

endmodule

// ===== rtl/unordered_key_set.sv =====
// Fixed-capacity set of nonzero keys: add, contains, remove and read by position.
// One request is processed at a time. An accepted request passes through the
// dispatch state and then, by case, the scan, the resolve state, the read
// wait state or the move state, and its response is loaded into the output
// register in the finish state. Add, contains and remove scan the occupied
// entries one per cycle through the single read port of the key memory and
// stop at the first match. A stalled response holds the next one in its final
// state until the beat is taken. Read by position and the null-key and
// out-of-range cases skip the scan. The response register holds a pending beat
// while the next request is already being taken and worked on.
// Remove fills the freed slot with the last entry, so entry order changes.
module unordered_key_set #(
  parameter int CAPACITY = uks_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = uks_pkg::KEY_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  uks_req_if.sink   req,
  uks_rsp_if.source rsp
);
  import uks_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  uks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .cmd       (cmd),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

  uks_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_op       (req.op),
    .req_key      (req.key),
    .req_position (req.position),
    .rsp_status   (rsp.status),
    .rsp_slot     (rsp.slot),
    .rsp_read_key (rsp.read_key),
    .rsp_count    (rsp.count)
  );

endmodule

// ===== rtl/uks_checker.sv =====
// Port-level checker for the key set, bound to the top level.
`include "unordered_key_set_assert.svh"

module uks_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [2:0]                  rsp_status,
  input logic [uks_pkg::SLOT_W-1:0]  rsp_slot,
  input logic [uks_pkg::KEY_W-1:0]   rsp_read_key,
  input logic [uks_pkg::CNT_W-1:0]   rsp_count
);

  `UKS_ASSERT_ALWAYS(a_rst_clears_rsp, rst |=> !rsp_valid, "response valid after reset")
  `UKS_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "request taken while busy")
  `UKS_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid, "stalled response dropped")
  `UKS_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_read_key) && $stable(rsp_count), "stalled response changed")

endmodule

bind unordered_key_set uks_checker u_uks_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_slot     (rsp.slot),
  .rsp_read_key (rsp.read_key),
  .rsp_count    (rsp.count)
);
